// ----- hdl/cspl_pkg.sv -----
// Shared types, constants and the divider step for the contrast stretch pipeline.
package cspl_pkg;

    localparam int PIX_W              = 8;
    localparam int CFG_IDX_W          = 2;
    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = PIX_W / DIV_STAGES;
    localparam int PIPE_DEPTH         = DIV_STAGES + 3;

    localparam logic [PIX_W-1:0] TOP_LEVEL = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_KNEE_IN   = 2'd0,
        REG_LOW_KNEE_OUT  = 2'd1,
        REG_HIGH_KNEE_IN  = 2'd2,
        REG_HIGH_KNEE_OUT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] low_knee_in;
        logic [PIX_W-1:0] low_knee_out;
        logic [PIX_W-1:0] high_knee_in;
        logic [PIX_W-1:0] high_knee_out;
    } knee_t;

    localparam knee_t KNEE_RESET = '{
        low_knee_in:   8'd64,
        low_knee_out:  8'd32,
        high_knee_in:  8'd192,
        high_knee_out: 8'd224
    };

    // Segment operands: result = base +/- (slope * offs) / den
    typedef struct packed {
        logic [PIX_W-1:0] slope;
        logic [PIX_W-1:0] offs;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] base;
        logic             neg;
        logic             dz;
    } seg_t;

    // Divider state: partial remainder, numerator bits still to shift in, quotient so far
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] quo;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] base;
        logic             neg;
        logic             dz;
    } div_t;

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    // The remainder stays below den, so the shifted value fits in PIX_W+1 bits.
    function automatic div_t div_step(input div_t d);
        div_t           r;
        logic [PIX_W:0] t;
        r     = d;
        t     = {d.rem, d.low[PIX_W-1]};
        r.low = {d.low[PIX_W-2:0], 1'b0};
        if (t >= {1'b0, d.den})
        begin
            r.rem = PIX_W'(t - {1'b0, d.den});
            r.quo = {d.quo[PIX_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[PIX_W-1:0];
            r.quo = {d.quo[PIX_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- hdl/cspl_cfg.sv -----
// Knee point registers written through the configuration port.
module cspl_cfg
    import cspl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    output knee_t                knee
);

    knee_t knee_reg;
    knee_t knee_next;

    always_comb
    begin
        knee_next = knee_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOW_KNEE_IN:   knee_next.low_knee_in   = cfg_data;
                REG_LOW_KNEE_OUT:  knee_next.low_knee_out  = cfg_data;
                REG_HIGH_KNEE_IN:  knee_next.high_knee_in  = cfg_data;
                REG_HIGH_KNEE_OUT: knee_next.high_knee_out = cfg_data;
                default:           knee_next = knee_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knee_reg <= KNEE_RESET;
        end
        else
        begin
            knee_reg <= knee_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign knee      = knee_reg;

endmodule

// ----- hdl/cspl_front.sv -----
// Segment select stage followed by the slope-times-offset multiply stage.
module cspl_front
    import cspl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  logic [PIX_W-1:0] pix,
    input  knee_t            knee,
    output logic             prod_valid,
    input  logic             prod_ready,
    output div_t             prod
);

    logic  seg_valid_reg;
    logic  seg_valid_next;
    seg_t  seg_reg;
    seg_t  seg_next;
    logic  seg_ready;

    logic  mul_valid_reg;
    logic  mul_valid_next;
    div_t  mul_reg;
    div_t  mul_next;
    logic  mul_ready;

    logic [2*PIX_W-1:0] product;

    // Pick the segment and form its unsigned operands
    always_comb
    begin
        seg_next = '0;
        if (pix < knee.low_knee_in)
        begin
            seg_next.slope = knee.low_knee_out;
            seg_next.offs  = pix;
            seg_next.den   = knee.low_knee_in;
            seg_next.base  = '0;
        end
        else if (pix < knee.high_knee_in)
        begin
            seg_next.neg   = knee.high_knee_out < knee.low_knee_out;
            seg_next.slope = seg_next.neg ? knee.low_knee_out - knee.high_knee_out
                                          : knee.high_knee_out - knee.low_knee_out;
            seg_next.offs  = pix - knee.low_knee_in;
            seg_next.den   = knee.high_knee_in - knee.low_knee_in;
            seg_next.base  = knee.low_knee_out;
        end
        else
        begin
            seg_next.slope = TOP_LEVEL - knee.high_knee_out;
            seg_next.offs  = pix - knee.high_knee_in;
            seg_next.den   = TOP_LEVEL - knee.high_knee_in;
            seg_next.base  = knee.high_knee_out;
            // high knee at the top level: the quotient is taken as zero
            seg_next.dz    = knee.high_knee_in == TOP_LEVEL;
        end
    end

    assign mul_ready      = !mul_valid_reg || prod_ready;
    assign seg_ready      = !seg_valid_reg || mul_ready;
    assign seg_valid_next = seg_ready ? pix_valid : seg_valid_reg;
    assign mul_valid_next = mul_ready ? seg_valid_reg : mul_valid_reg;

    assign product = seg_reg.slope * seg_reg.offs;

    always_comb
    begin
        mul_next      = '0;
        mul_next.rem  = product[2*PIX_W-1:PIX_W];
        mul_next.low  = product[PIX_W-1:0];
        mul_next.den  = seg_reg.den;
        mul_next.base = seg_reg.base;
        mul_next.neg  = seg_reg.neg;
        mul_next.dz   = seg_reg.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
            mul_valid_reg <= mul_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_ready)
        begin
            seg_reg <= seg_next;
        end
        if (mul_ready)
        begin
            mul_reg <= mul_next;
        end
    end

    assign pix_ready  = seg_ready;
    assign prod_valid = mul_valid_reg;
    assign prod       = mul_reg;

endmodule

// ----- hdl/cspl_div_stage.sv -----
// One divider stage: resolves DIV_BITS_PER_STAGE (two) quotient bits per beat.
module cspl_div_stage
    import cspl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  div_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output div_t dn_data
);

    logic valid_reg;
    logic valid_next;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        data_next = up_data;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            data_next = div_step(data_next);
        end
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- hdl/cspl_out.sv -----
// Output stage: applies the quotient to the segment base, clamps, holds the result beat.
module cspl_out
    import cspl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  div_t             up_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] gray_out
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] gray_reg;
    logic [PIX_W-1:0] gray_next;
    logic [PIX_W-1:0] quo;
    logic [PIX_W:0]   sum;

    assign quo = up_data.dz ? '0 : up_data.quo;
    assign sum = {1'b0, up_data.base} + {1'b0, quo};

    always_comb
    begin
        if (up_data.neg)
        begin
            // drop to zero when the falling slope runs below the floor
            gray_next = (quo > up_data.base) ? '0 : up_data.base - quo;
        end
        else
        begin
            gray_next = sum[PIX_W] ? TOP_LEVEL : sum[PIX_W-1:0];
        end
    end

    assign up_ready   = !valid_reg || !out_stall;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            gray_reg <= gray_next;
        end
    end

    assign out_valid = valid_reg;
    assign gray_out  = gray_reg;

endmodule

// ----- hdl/contrast_stretch_piecewise_linear.sv -----
// Top level of the piecewise-linear contrast stretch pipeline.
// Maps each 8-bit gray pixel through the curve (0,0)-(low knee)-(high knee)-(255,255),
// truncating every segment quotient toward zero and clamping to 0..255. One pixel is
// accepted per clock when nothing stalls; each result passes through the stages in order:
// one stage picks the segment, one does the 8x8 multiply, four divider stages
// resolve two quotient bits each, and one stage adds the segment base and clamps. A stall
// on the output backs up stage by stage; empty stages keep filling meanwhile. The four
// knee registers take writes at any clock (cfg_ready is always high), but are meant to be
// written only while no pixel is in flight.
module contrast_stretch_piecewise_linear
    import cspl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     gray_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     gray_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data
);

    knee_t                knee;
    logic                 pix_ready;
    logic [DIV_STAGES:0]  div_valid;
    logic [DIV_STAGES:0]  div_ready;
    div_t                 div_data [DIV_STAGES+1];

    cspl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .knee      (knee)
    );

    cspl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (in_valid),
        .pix_ready  (pix_ready),
        .pix        (gray_in),
        .knee       (knee),
        .prod_valid (div_valid[0]),
        .prod_ready (div_ready[0]),
        .prod       (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        cspl_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[g]),
            .up_ready (div_ready[g]),
            .up_data  (div_data[g]),
            .dn_valid (div_valid[g+1]),
            .dn_ready (div_ready[g+1]),
            .dn_data  (div_data[g+1])
        );
    end

    cspl_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (div_valid[DIV_STAGES]),
        .up_ready  (div_ready[DIV_STAGES]),
        .up_data   (div_data[DIV_STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .gray_out  (gray_out)
    );

    assign in_stall = !pix_ready;

endmodule

// ----- hdl/cspl_checker.sv -----
// Port-level checker for the contrast stretch pipeline and its bind to the top level.
module cspl_checker
    import cspl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [PIX_W-1:0]     gray_out
);

    localparam int QUIET_W = $clog2(PIPE_DEPTH + 1);

    logic               quiet;
    logic [QUIET_W-1:0] quiet_cnt_reg;
    logic [QUIET_W-1:0] quiet_cnt_next;

    // a quiet cycle takes no input beat and lets the output drain
    assign quiet = !(in_valid && !in_stall) && !out_stall;

    always_comb
    begin
        if (!quiet)
        begin
            quiet_cnt_next = '0;
        end
        else if (quiet_cnt_reg == QUIET_W'(PIPE_DEPTH))
        begin
            quiet_cnt_next = quiet_cnt_reg;
        end
        else
        begin
            quiet_cnt_next = quiet_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cnt_reg <= '0;
        end
        else
        begin
            quiet_cnt_reg <= quiet_cnt_next;
        end
    end

    // with the sink open, every stage can advance, so the input never stalls
    a_no_stall_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is open");

    // a full pipeline depth of quiet cycles leaves nothing to deliver
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        quiet_cnt_reg == QUIET_W'(PIPE_DEPTH) |-> !out_valid)
        else $error("result beat without a matching input beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gray_out))
        else $error("stalled output beat changed");

endmodule

bind contrast_stretch_piecewise_linear cspl_checker u_cspl_checker (.*);
